/* design/bas_pkg.sv */
// shared constants, types and table functions of the approximation search
package bas_pkg;

  // number of variables of the target function
  localparam int unsigned NUM_VARS = 6;

  // fixed field widths
  localparam int unsigned MAX_BITS  = 64;
  localparam int unsigned CAND_W    = 32;
  localparam int unsigned FV_W      = 3;
  localparam int unsigned CNT_W     = 7;

  // table sizes that follow from the variable count
  localparam int unsigned TBL_BITS  = 1 << NUM_VARS;
  localparam int unsigned CAND_BITS = TBL_BITS / 2;

  // popcount is split into groups of eight entries
  localparam int unsigned GRP_SIZE  = 8;
  localparam int unsigned NUM_GRP   = MAX_BITS / GRP_SIZE;
  localparam int unsigned GRP_CNT_W = 4;

  // masks of the entries that take part
  localparam logic [MAX_BITS-1:0] FULL_MASK = {MAX_BITS{1'b1}} >> (MAX_BITS - TBL_BITS);
  localparam logic [CAND_W-1:0]   CAND_MASK = {CAND_W{1'b1}} >> (CAND_W - CAND_BITS);

  // pipeline advance enables for the match unit
  typedef struct packed {
    logic en_s1;
    logic en_s2;
    logic en_s3;
  } bas_pipe_ctrl_t;

  // one candidate with its match count for every ignored variable
  typedef struct packed {
    logic [CAND_W-1:0]                 cand;
    logic                              restart;
    logic [NUM_VARS-1:0][CNT_W-1:0]    match_cnt;
  } bas_judge_t;

  // widen a candidate table so that variable var_idx is ignored
  function automatic logic [MAX_BITS-1:0] widen(input logic [CAND_W-1:0] cand,
                                                input int unsigned var_idx);
    int unsigned s;
    int unsigned low;
    int unsigned high;
    logic [4:0] idx;
    logic [MAX_BITS-1:0] res;
    s   = NUM_VARS - 1 - var_idx;
    res = '0;
    for (int unsigned i = 0; i < MAX_BITS; i++) begin
      low  = i & ((32'd1 << s) - 32'd1);
      high = i >> (s + 1);
      idx  = 5'((high << s) | low);
      res[i] = cand[idx];
    end
    return res;
  endfunction

  // number of ones in a group of eight entries
  function automatic logic [GRP_CNT_W-1:0] ones8(input logic [GRP_SIZE-1:0] b);
    logic [GRP_CNT_W-1:0] n;
    n = '0;
    for (int unsigned i = 0; i < GRP_SIZE; i++) begin
      n = n + GRP_CNT_W'(b[i]);
    end
    return n;
  endfunction

endpackage

/* design/bas_in_if.sv */
// candidate item channel: valid, ready and payload
interface bas_in_if;
  logic                        valid;
  logic                        ready;
  logic [bas_pkg::CAND_W-1:0]  candidate_table;
  logic                        restart;

  modport source (output valid, output candidate_table, output restart, input ready);
  modport sink   (input valid, input candidate_table, input restart, output ready);
endinterface

/* design/bas_out_if.sv */
// result item channel: valid, ready and payload
interface bas_out_if;
  logic                        valid;
  logic                        ready;
  logic [bas_pkg::CAND_W-1:0]  best_table;
  logic [bas_pkg::FV_W-1:0]    best_free_var;
  logic [bas_pkg::CNT_W-1:0]   best_matches;
  logic                        improved;

  modport source (output valid, output best_table, output best_free_var,
                  output best_matches, output improved, input ready);
  modport sink   (input valid, input best_table, input best_free_var,
                  input best_matches, input improved, output ready);
endinterface

/* design/boolean_approximation_search_core.sv */
// top level of the boolean best-approximation search
//
// in_if carries a 32-bit candidate truth table of a 5-variable function and a
// restart flag. cfg_wr_en/cfg_wr_data write the 64-bit target table; write it
// only while no item is in flight. For every accepted candidate one result item
// appears on out_if: the best table so far, the variable it ignores, its match
// count against the target and whether this candidate improved it.
// Throughput is one item per cycle while the receiver does not stall, set by
// the four-stage pipeline: input register, group popcounts, match count sums,
// and the best-tracking result register whose feedback compare chain is the
// only loop.
// When the receiver stalls, the result register holds and each stage keeps
// its item; empty stages still fill, so up to three more items are accepted
// before in_if.ready drops.
// Synchronous reset clears the target, the kept best and all stage valids;
// the block accepts an item in the first cycle after reset.
module boolean_approximation_search_core (
  input  logic                          clk,
  input  logic                          rst_n,
  bas_in_if.sink                        in_if,
  bas_out_if.source                     out_if,
  input  logic                          cfg_wr_en,
  input  logic [bas_pkg::MAX_BITS-1:0]  cfg_wr_data
);

  logic [bas_pkg::MAX_BITS-1:0] target_r;
  logic v1_r, v2_r, v3_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4;
  bas_pkg::bas_pipe_ctrl_t ctrl;
  logic en_out;
  bas_pkg::bas_judge_t judge;
  logic [bas_pkg::CAND_W-1:0] best_table;
  logic [bas_pkg::FV_W-1:0]   best_free_var;
  logic [bas_pkg::CNT_W-1:0]  best_matches;
  logic                       improved;

  // target register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr_en) begin
      target_r <= cfg_wr_data;
    end
  end

  // per-stage ready chain, bubbles collapse under a stall
  assign rdy4 = !out_v_r || out_if.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign ctrl.en_s1 = rdy1 && in_if.valid;
  assign ctrl.en_s2 = rdy2 && v1_r;
  assign ctrl.en_s3 = rdy3 && v2_r;
  assign en_out     = rdy4 && v3_r;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_if.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        out_v_r <= v3_r;
      end
    end
  end

  // match counting pipeline
  bas_match_unit u_match (
    .clk        (clk),
    .ctrl       (ctrl),
    .cand_in    (in_if.candidate_table),
    .restart_in (in_if.restart),
    .target     (target_r),
    .judge      (judge)
  );

  // running best and result register
  bas_best_tracker u_best (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en_out),
    .judge         (judge),
    .best_table    (best_table),
    .best_free_var (best_free_var),
    .best_matches  (best_matches),
    .improved      (improved)
  );

  // channel outputs
  assign in_if.ready          = rdy1;
  assign out_if.valid         = out_v_r;
  assign out_if.best_table    = best_table;
  assign out_if.best_free_var = best_free_var;
  assign out_if.best_matches  = best_matches;
  assign out_if.improved      = improved;

`ifndef SYNTHESIS
  // an improvement always leaves a non-zero count
  a_improved_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && improved |-> best_matches != '0)
    else $error("improved result with zero matches");

  // kept variable stays within the variable range
  a_free_var_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> best_free_var < bas_pkg::FV_W'(bas_pkg::NUM_VARS))
    else $error("kept free variable out of range");

  // without restart the kept count never falls
  a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    en_out && !judge.restart |=> best_matches >= $past(best_matches))
    else $error("kept match count decreased without restart");

  // count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    best_matches <= bas_pkg::CNT_W'(bas_pkg::TBL_BITS))
    else $error("kept match count above table size");
`endif

endmodule

/* design/bas_match_unit.sv */
// three-stage match counter: input register, group popcounts, match counts
module bas_match_unit (
  input  logic                          clk,
  input  bas_pkg::bas_pipe_ctrl_t       ctrl,
  input  logic [bas_pkg::CAND_W-1:0]    cand_in,
  input  logic                          restart_in,
  input  logic [bas_pkg::MAX_BITS-1:0]  target,
  output bas_pkg::bas_judge_t           judge
);

  // stage one: captured item
  logic [bas_pkg::CAND_W-1:0] cand_s1_r;
  logic                       restart_s1_r;

  // stage two: per-group mismatch counts
  logic [bas_pkg::CAND_W-1:0]    cand_s2_r;
  logic                          restart_s2_r;
  logic [bas_pkg::GRP_CNT_W-1:0] grp_cnt_r   [bas_pkg::NUM_VARS][bas_pkg::NUM_GRP];
  logic [bas_pkg::GRP_CNT_W-1:0] grp_cnt_nxt [bas_pkg::NUM_VARS][bas_pkg::NUM_GRP];

  // stage three: match counts
  bas_pkg::bas_judge_t judge_r;
  bas_pkg::bas_judge_t judge_nxt;

  // mismatch popcount per group of eight entries
  always_comb begin
    logic [bas_pkg::MAX_BITS-1:0] diff;
    for (int unsigned v = 0; v < bas_pkg::NUM_VARS; v++) begin
      diff = (bas_pkg::widen(cand_s1_r, v) ^ target) & bas_pkg::FULL_MASK;
      for (int unsigned g = 0; g < bas_pkg::NUM_GRP; g++) begin
        grp_cnt_nxt[v][g] = bas_pkg::ones8(diff[g*bas_pkg::GRP_SIZE +: bas_pkg::GRP_SIZE]);
      end
    end
  end

  // sum the groups and turn mismatches into matches
  always_comb begin
    logic [bas_pkg::CNT_W-1:0] miss;
    judge_nxt.cand    = cand_s2_r;
    judge_nxt.restart = restart_s2_r;
    for (int unsigned v = 0; v < bas_pkg::NUM_VARS; v++) begin
      miss = '0;
      for (int unsigned g = 0; g < bas_pkg::NUM_GRP; g++) begin
        miss = miss + bas_pkg::CNT_W'(grp_cnt_r[v][g]);
      end
      judge_nxt.match_cnt[v] = bas_pkg::CNT_W'(bas_pkg::TBL_BITS) - miss;
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (ctrl.en_s1) begin
      cand_s1_r    <= cand_in & bas_pkg::CAND_MASK;
      restart_s1_r <= restart_in;
    end
    if (ctrl.en_s2) begin
      cand_s2_r    <= cand_s1_r;
      restart_s2_r <= restart_s1_r;
      grp_cnt_r    <= grp_cnt_nxt;
    end
    if (ctrl.en_s3) begin
      judge_r <= judge_nxt;
    end
  end

  assign judge = judge_r;

endmodule

/* design/bas_best_tracker.sv */
// running best: compares the six match counts against the kept best
module bas_best_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  bas_pkg::bas_judge_t         judge,
  output logic [bas_pkg::CAND_W-1:0]  best_table,
  output logic [bas_pkg::FV_W-1:0]    best_free_var,
  output logic [bas_pkg::CNT_W-1:0]   best_matches,
  output logic                        improved
);

  // kept best, also the result register
  logic [bas_pkg::CAND_W-1:0] kept_table_r,    kept_table_nxt;
  logic [bas_pkg::FV_W-1:0]   kept_free_var_r, kept_free_var_nxt;
  logic [bas_pkg::CNT_W-1:0]  kept_matches_r,  kept_matches_nxt;
  logic                       improved_r,      improved_nxt;

  // strictly greater count wins, lower variable first
  always_comb begin
    if (judge.restart) begin
      kept_table_nxt    = '0;
      kept_free_var_nxt = '0;
      kept_matches_nxt  = '0;
    end else begin
      kept_table_nxt    = kept_table_r;
      kept_free_var_nxt = kept_free_var_r;
      kept_matches_nxt  = kept_matches_r;
    end
    improved_nxt = 1'b0;
    for (int unsigned v = 0; v < bas_pkg::NUM_VARS; v++) begin
      if (judge.match_cnt[v] > kept_matches_nxt) begin
        kept_table_nxt    = judge.cand;
        kept_free_var_nxt = bas_pkg::FV_W'(v);
        kept_matches_nxt  = judge.match_cnt[v];
        improved_nxt      = 1'b1;
      end
    end
  end

  // update on each judged item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_table_r    <= '0;
      kept_free_var_r <= '0;
      kept_matches_r  <= '0;
      improved_r      <= 1'b0;
    end else if (en) begin
      kept_table_r    <= kept_table_nxt;
      kept_free_var_r <= kept_free_var_nxt;
      kept_matches_r  <= kept_matches_nxt;
      improved_r      <= improved_nxt;
    end
  end

  assign best_table    = kept_table_r;
  assign best_free_var = kept_free_var_r;
  assign best_matches  = kept_matches_r;
  assign improved      = improved_r;

endmodule

/* verif/tb.sv */
// self-checking bench for the boolean best-approximation search core
module tb;

  localparam int unsigned LONG_HOLD  = 60;
  localparam int unsigned DRAIN_WAIT = 8;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned PHASE_LEN  = 155;
  localparam int unsigned N_DIR      = 20;

  // one result item as the block reports it
  typedef struct packed {
    logic [bas_pkg::CAND_W-1:0] tab;
    logic [bas_pkg::FV_W-1:0]   fv;
    logic [bas_pkg::CNT_W-1:0]  cnt;
    logic                       imp;
  } best_rec_t;

  // one directed item, with an optional target load before it
  typedef struct packed {
    logic                         set_tgt;
    logic [bas_pkg::MAX_BITS-1:0] tgt;
    logic [bas_pkg::CAND_W-1:0]   cand;
    logic                         rst;
    logic                         typed;
    best_rec_t                    want;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [bas_pkg::MAX_BITS-1:0] cfg_wr_data;

  bas_in_if  in_if ();
  bas_out_if out_if ();

  boolean_approximation_search_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // own copy of target and kept best
  logic [bas_pkg::MAX_BITS-1:0] tgt_table;
  logic [bas_pkg::CAND_W-1:0]   best_tab;
  logic [bas_pkg::FV_W-1:0]     best_var;
  logic [bas_pkg::CNT_W-1:0]    best_cnt;

  best_rec_t pending_best[$];
  int unsigned mismatches = 0;

  // idling controls of sender and receiver
  bit send_gaps   = 1'b0;
  bit recv_stalls = 1'b0;
  bit hold_req    = 1'b0;

  // directed items: reset state, all-zero and all-one tables, exact fits, ties
  dir_row_t dir_rows [N_DIR] = '{
    '{1'b0, 64'h0, 32'h0000_0000, 1'b0, 1'b1, '{32'h0000_0000, 3'd0, 7'd64, 1'b1}},
    '{1'b0, 64'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, '{32'h0000_0000, 3'd0, 7'd64, 1'b0}},
    '{1'b0, 64'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'h0000_0000, 3'd0, 7'd0, 1'b0}},
    '{1'b0, 64'h0, 32'h0000_0000, 1'b0, 1'b1, '{32'h0000_0000, 3'd0, 7'd64, 1'b1}},
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1,
      '{32'h0000_0000, 3'd0, 7'd0, 1'b0}},
    '{1'b0, 64'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, '{32'hFFFF_FFFF, 3'd0, 7'd64, 1'b1}},
    '{1'b1, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_0000, 1'b1, 1'b1,
      '{32'hFFFF_0000, 3'd1, 7'd64, 1'b1}},
    '{1'b0, 64'h0, 32'h0000_FFFF, 1'b0, 1'b1, '{32'hFFFF_0000, 3'd1, 7'd64, 1'b0}},
    '{1'b1, 64'h6996_9669_9669_6996, 32'h6996_9669, 1'b1, 1'b0, '0},
    '{1'b0, 64'h0, 32'h9669_6996, 1'b0, 1'b0, '0},
    '{1'b1, 64'h8000_0000_0000_0001, 32'h0000_0001, 1'b1, 1'b0, '0},
    '{1'b0, 64'h0, 32'h8000_0000, 1'b0, 1'b0, '0},
    '{1'b0, 64'h0, 32'hAAAA_AAAA, 1'b1, 1'b0, '0},
    '{1'b0, 64'h0, 32'h5555_5555, 1'b0, 1'b0, '0},
    '{1'b1, 64'h0123_4567_89AB_CDEF, 32'h89AB_CDEF, 1'b1, 1'b0, '0},
    '{1'b0, 64'h0, 32'h0123_4567, 1'b0, 1'b0, '0},
    '{1'b0, 64'h0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b1, 1'b1,
      '{32'hAAAA_AAAA, 3'd0, 7'd64, 1'b1}},
    '{1'b0, 64'h0, 32'h0F0F_0F0F, 1'b1, 1'b0, '0},
    '{1'b0, 64'h0, 32'h0000_0000, 1'b0, 1'b0, '0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #1000000;
    $display("tb failed");
    $finish;
  end

  // entries where the candidate, widened with drop_var ignored, agrees with the target
  function automatic int unsigned agree_count(input logic [bas_pkg::CAND_W-1:0] cand,
                                              input int unsigned drop_var);
    int unsigned n;
    int unsigned s;
    int unsigned ci;
    n = 0;
    s = bas_pkg::NUM_VARS - 1 - drop_var;
    for (int unsigned i = 0; i < bas_pkg::TBL_BITS; i++) begin
      ci = ((i >> (s + 1)) << s) | (i & ((1 << s) - 1));
      if (cand[ci & (bas_pkg::CAND_BITS - 1)] == tgt_table[i]) n++;
    end
    return n;
  endfunction

  // judge one candidate against the kept best and return the new best
  function automatic best_rec_t judge_candidate(input logic [bas_pkg::CAND_W-1:0] cand,
                                                input logic rst);
    best_rec_t res;
    int unsigned m;
    res.imp = 1'b0;
    if (rst) begin
      best_tab = '0;
      best_var = '0;
      best_cnt = '0;
    end
    for (int unsigned v = 0; v < bas_pkg::NUM_VARS; v++) begin
      m = agree_count(cand & bas_pkg::CAND_MASK, v);
      if (m > best_cnt) begin
        best_tab = cand & bas_pkg::CAND_MASK;
        best_var = bas_pkg::FV_W'(v);
        best_cnt = bas_pkg::CNT_W'(m);
        res.imp  = 1'b1;
      end
    end
    res.tab = best_tab;
    res.fv  = best_var;
    res.cnt = best_cnt;
    return res;
  endfunction

  task automatic note_mismatch(input string field,
                               input logic [bas_pkg::CAND_W-1:0] got,
                               input logic [bas_pkg::CAND_W-1:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    mismatches++;
  endtask

  // offer one item and return at the edge that accepts it
  task automatic offer_item(input logic [bas_pkg::CAND_W-1:0] cand, input logic rst);
    in_if.valid           <= 1'b1;
    in_if.candidate_table <= cand;
    in_if.restart         <= rst;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // wait until the block is idle, then write the target table
  task automatic load_target(input logic [bas_pkg::MAX_BITS-1:0] value);
    in_if.valid <= 1'b0;
    while (pending_best.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tgt_table = value;
  endtask

  // random candidate: plain noise, near-copies of the target, or simple patterns
  function automatic logic [bas_pkg::CAND_W-1:0] pick_candidate();
    logic [bas_pkg::CAND_W-1:0] flips;
    flips = '0;
    repeat ($urandom_range(0, 3)) flips[$urandom_range(0, bas_pkg::CAND_W - 1)] = 1'b1;
    case ($urandom_range(0, 5))
      0, 1:    return $urandom();
      2:       return tgt_table[bas_pkg::CAND_W-1:0] ^ flips;
      3:       return tgt_table[bas_pkg::MAX_BITS-1:bas_pkg::CAND_W] ^ flips;
      4:       return ($urandom_range(0, 1) != 0) ? ~flips : flips;
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  // result receiver: random stall bursts, plus one long hold on request
  initial begin : drive_ready
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (recv_stalls && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // compare every accepted result item with the oldest expectation
  initial begin : check_results
    best_rec_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_best.size() == 0) begin
          note_mismatch("unexpected item", out_if.best_table, '0);
        end else begin
          want = pending_best.pop_front();
          if (out_if.best_table !== want.tab)
            note_mismatch("best_table", out_if.best_table, want.tab);
          if (out_if.best_free_var !== want.fv)
            note_mismatch("best_free_var", bas_pkg::CAND_W'(out_if.best_free_var),
                          bas_pkg::CAND_W'(want.fv));
          if (out_if.best_matches !== want.cnt)
            note_mismatch("best_matches", bas_pkg::CAND_W'(out_if.best_matches),
                          bas_pkg::CAND_W'(want.cnt));
          if (out_if.improved !== want.imp)
            note_mismatch("improved", bas_pkg::CAND_W'(out_if.improved),
                          bas_pkg::CAND_W'(want.imp));
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    best_rec_t                    rec;
    logic [bas_pkg::CAND_W-1:0]   half;
    logic [bas_pkg::CAND_W-1:0]   cand;
    logic [bas_pkg::MAX_BITS-1:0] phase_tgt;
    bit                           in_hold;

    rst_n                 <= 1'b0;
    cfg_wr_en             <= 1'b0;
    cfg_wr_data           <= '0;
    in_if.valid           <= 1'b0;
    in_if.candidate_table <= '0;
    in_if.restart         <= 1'b0;
    tgt_table = '0;
    best_tab  = '0;
    best_var  = '0;
    best_cnt  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed items
    for (int k = 0; k < N_DIR; k++) begin
      if (dir_rows[k].set_tgt) load_target(dir_rows[k].tgt);
      offer_item(dir_rows[k].cand, dir_rows[k].rst);
      rec = judge_candidate(dir_rows[k].cand, dir_rows[k].rst);
      pending_best.push_back(dir_rows[k].typed ? dir_rows[k].want : rec);
    end

    // random phases, each with its own target
    for (int p = 0; p < NUM_PHASES; p++) begin
      half = $urandom();
      case (p)
        0:       phase_tgt = '1;
        2:       phase_tgt = {half, half};
        3:       phase_tgt = '0;
        default: phase_tgt = {$urandom(), $urandom()};
      endcase
      load_target(phase_tgt);
      send_gaps   = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      recv_stalls = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);

      for (int n = 0; n < PHASE_LEN; n++) begin
        // long receiver hold while items keep coming back to back
        if (p == 2 && n == 40) hold_req = 1'b1;
        in_hold = (p == 2 && n >= 40 && n < 75);
        // sender waits for every result before going on
        if (p == 3 && n == 70) begin
          in_if.valid <= 1'b0;
          while (pending_best.size() != 0) @(posedge clk);
        end else if (send_gaps && !in_hold && $urandom_range(0, 3) == 0) begin
          in_if.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        cand = pick_candidate();
        offer_item(cand, $urandom_range(0, 15) == 0);
        rec = judge_candidate(cand, in_if.restart);
        pending_best.push_back(rec);
      end
    end

    // drain
    in_if.valid <= 1'b0;
    while (pending_best.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
